### src/tfe_pkg.sv
package tfe_pkg;

    // frame phases, in transmission order
    typedef enum logic [3:0] {
        PH_SYNC,
        PH_MARK,
        PH_ID,
        PH_ADDR,
        PH_DATA,
        PH_DEND,
        PH_CSUM,
        PH_EOT,
        PH_DONE
    } phase_t;

    typedef enum logic {
        OP_TICK,
        OP_BYTE
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data_byte;
        logic       last_byte;
    } cmd_t;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               sample_valid;
        logic               need_byte;
        logic               overrun;
        logic               frame_done;
    } res_t;

    typedef struct packed {
        logic [15:0] start_address;
        logic [15:0] data_length;
        logic [7:0]  file_id;
    } cfg_t;

    // configuration register map
    localparam int unsigned PADDR_W = 4;
    localparam logic [1:0] REG_START_ADDRESS = 2'd0;
    localparam logic [1:0] REG_DATA_LENGTH   = 2'd1;
    localparam logic [1:0] REG_FILE_ID       = 2'd2;

    // character codes
    localparam logic [7:0] CH_SYNC  = 8'h16;
    localparam logic [7:0] CH_MARK  = 8'h2A;
    localparam logic [7:0] CH_DEND  = 8'h2F;
    localparam logic [7:0] CH_EOT   = 8'h04;
    localparam logic [7:0] CH_DIGIT = 8'h30;
    localparam logic [7:0] CH_ALPHA = 8'h41;

    localparam logic signed [15:0] SAMPLE_HIGH = 16'sh7FFF;
    localparam logic signed [15:0] SAMPLE_LOW  = 16'sh8000;

    // tone timing
    localparam logic [3:0] FAST_HALF    = 4'd6;
    localparam logic [3:0] FAST_PERIODS = 4'd9;
    localparam logic [3:0] SLOW_HALF    = 4'd9;
    localparam logic [3:0] SLOW_PERIODS = 4'd6;
    localparam logic [1:0] LAST_TONE    = 2'd2;

    // characters per fixed phase
    localparam int unsigned CNT_W = 7;
    localparam logic [CNT_W-1:0] MARK_CHARS = 7'd1;
    localparam logic [CNT_W-1:0] ID_CHARS   = 7'd2;
    localparam logic [CNT_W-1:0] ADDR_CHARS = 7'd4;
    localparam logic [CNT_W-1:0] DEND_CHARS = 7'd1;
    localparam logic [CNT_W-1:0] CSUM_CHARS = 7'd4;
    localparam logic [CNT_W-1:0] EOT_CHARS  = 7'd2;

    localparam int unsigned QUEUE_DEPTH = 2;

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
        begin
            return CH_DIGIT + {4'd0, n};
        end
        else
        begin
            return CH_ALPHA + {4'd0, n} - 8'd10;
        end
    endfunction

    // nibble order: low byte hi, low byte lo, high byte hi, high byte lo
    function automatic logic [7:0] word_nibble(input logic [15:0] w, input logic [1:0] k);
        case (k)
            2'd0:    return hex_char(w[7:4]);
            2'd1:    return hex_char(w[3:0]);
            2'd2:    return hex_char(w[15:12]);
            default: return hex_char(w[11:8]);
        endcase
    endfunction

endpackage

### src/tfe_front.sv
module tfe_front
    import tfe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       kind,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       push,
    output cmd_t       push_cmd,
    input  logic       queue_full
);

    logic valid_reg;
    logic valid_next;
    cmd_t cmd_reg;
    logic take;

    assign push     = valid_reg && !queue_full;
    assign in_ready = !valid_reg || !queue_full;
    assign take     = in_valid && in_ready;
    assign push_cmd = cmd_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // classify the transaction
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg.op        <= kind ? OP_BYTE : OP_TICK;
            cmd_reg.data_byte <= data_byte;
            cmd_reg.last_byte <= last_byte;
        end
    end

endmodule

### src/tfe_queue.sv
module tfe_queue
    import tfe_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic pop_valid,
    output cmd_t pop_cmd
);

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_QW = $clog2(QUEUE_DEPTH + 1);

    cmd_t              mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_QW-1:0] count_reg;
    logic [CNT_QW-1:0] count_next;

    assign full      = (count_reg == CNT_QW'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_cmd   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### src/tfe_back.sv
module tfe_back
    import tfe_pkg::*;
#(
    parameter int unsigned SYNC_CHARS = 100
)
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic cmd_valid,
    input  cmd_t cmd,
    output logic cmd_pop,
    output logic out_valid,
    input  logic out_ready,
    output res_t res
);

    localparam logic [CNT_W-1:0] SYNC_LIMIT = CNT_W'(SYNC_CHARS);

    phase_t           phase_reg,      phase_next;
    logic [CNT_W-1:0] count_reg,      count_next;
    logic [15:0]      data_sent_reg,  data_sent_next;
    logic             low_nibble_reg, low_nibble_next;
    logic [7:0]       tape_char_reg,  tape_char_next;
    logic [2:0]       bit_reg,        bit_next;
    logic [1:0]       tone_reg,       tone_next;
    logic [3:0]       period_reg,     period_next;
    logic [3:0]       samp_reg,       samp_next;
    logic             half_low_reg,   half_low_next;
    logic [15:0]      sum_reg,        sum_next;
    logic [7:0]       held_byte_reg,  held_byte_next;
    logic             held_valid_reg, held_valid_next;
    logic             ended_reg,      ended_next;
    logic             out_valid_reg,  out_valid_next;
    res_t             res_reg,        res_next;

    phase_t           ph;
    logic [CNT_W-1:0] cnt;
    logic             exhausted;
    logic             data_empty;
    logic             char_start;
    logic             ready;
    logic [7:0]       ch;
    logic             slow;
    logic [3:0]       half_len;
    logic [3:0]       periods;
    logic [15:0]      csum;
    logic [3:0]       samp_inc;
    logic [3:0]       period_inc;
    res_t             res_new;

    assign cmd_pop   = cmd_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign res       = res_reg;

    assign csum = sum_reg + {8'd0, cfg.start_address[7:0]} + {8'd0, cfg.start_address[15:8]};
    assign char_start = (bit_reg == 3'd0) && (tone_reg == 2'd0) && (period_reg == 4'd0)
                        && (samp_reg == 4'd0) && !half_low_reg;
    assign data_empty = !low_nibble_reg && !held_valid_reg
                        && (ended_reg || data_sent_reg >= cfg.data_length);

    // has the current phase sent all of its characters
    always_comb
    begin
        case (phase_reg)
            PH_SYNC: exhausted = count_reg >= SYNC_LIMIT;
            PH_MARK: exhausted = count_reg >= MARK_CHARS;
            PH_ID:   exhausted = count_reg >= ID_CHARS;
            PH_ADDR: exhausted = count_reg >= ADDR_CHARS;
            PH_DEND: exhausted = count_reg >= DEND_CHARS;
            PH_CSUM: exhausted = count_reg >= CSUM_CHARS;
            PH_EOT:  exhausted = count_reg >= EOT_CHARS;
            default: exhausted = 1'b0;
        endcase
    end

    always_comb
    begin
        phase_next      = phase_reg;
        count_next      = count_reg;
        data_sent_next  = data_sent_reg;
        low_nibble_next = low_nibble_reg;
        tape_char_next  = tape_char_reg;
        bit_next        = bit_reg;
        tone_next       = tone_reg;
        period_next     = period_reg;
        samp_next       = samp_reg;
        half_low_next   = half_low_reg;
        sum_next        = sum_reg;
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        ended_next      = ended_reg;
        res_new         = '0;
        ph              = phase_reg;
        cnt             = count_reg;
        ready           = 1'b1;
        ch              = tape_char_reg;
        slow            = 1'b0;
        half_len        = FAST_HALF;
        periods         = FAST_PERIODS;
        samp_inc        = samp_reg + 4'd1;
        period_inc      = period_reg + 4'd1;

        if (cmd_pop)
        begin
            if (cmd.op == OP_BYTE)
            begin
                if (phase_reg <= PH_DATA && !held_valid_reg && !ended_reg
                    && data_sent_reg < cfg.data_length)
                begin
                    held_byte_next  = cmd.data_byte;
                    held_valid_next = 1'b1;
                    data_sent_next  = data_sent_reg + 16'd1;
                    sum_next        = sum_reg + {8'd0, cmd.data_byte};
                    ended_next      = ended_reg || cmd.last_byte;
                end
                else
                begin
                    res_new.overrun = 1'b1;
                end
            end
            else if (phase_reg != PH_DONE)
            begin
                if (char_start)
                begin
                    // skip a finished phase, then an empty data phase
                    if (exhausted)
                    begin
                        ph  = phase_t'(4'(phase_reg) + 4'd1);
                        cnt = '0;
                    end
                    if (ph == PH_DATA && data_empty)
                    begin
                        ph  = PH_DEND;
                        cnt = '0;
                    end
                    case (ph)
                        PH_SYNC:
                        begin
                            ch  = CH_SYNC;
                            cnt = cnt + 1'b1;
                        end
                        PH_MARK:
                        begin
                            ch  = CH_MARK;
                            cnt = cnt + 1'b1;
                        end
                        PH_ID:
                        begin
                            ch  = hex_char((cnt == '0) ? cfg.file_id[7:4] : cfg.file_id[3:0]);
                            cnt = cnt + 1'b1;
                        end
                        PH_ADDR:
                        begin
                            ch  = word_nibble(cfg.start_address, cnt[1:0]);
                            cnt = cnt + 1'b1;
                        end
                        PH_DATA:
                        begin
                            if (low_nibble_reg)
                            begin
                                ch              = hex_char(held_byte_reg[3:0]);
                                held_valid_next = 1'b0;
                                low_nibble_next = 1'b0;
                            end
                            else if (held_valid_reg)
                            begin
                                ch              = hex_char(held_byte_reg[7:4]);
                                low_nibble_next = 1'b1;
                            end
                            else
                            begin
                                ready = 1'b0;
                            end
                        end
                        PH_DEND:
                        begin
                            ch  = CH_DEND;
                            cnt = cnt + 1'b1;
                        end
                        PH_CSUM:
                        begin
                            ch  = word_nibble(csum, cnt[1:0]);
                            cnt = cnt + 1'b1;
                        end
                        PH_EOT:
                        begin
                            ch  = CH_EOT;
                            cnt = cnt + 1'b1;
                        end
                        default:
                        begin
                            ready = 1'b0;
                        end
                    endcase
                    phase_next = ph;
                    count_next = cnt;
                    if (ready)
                    begin
                        tape_char_next = ch;
                    end
                end

                if (!ready)
                begin
                    res_new.need_byte = (ph == PH_DATA);
                end
                else
                begin
                    slow     = (tone_reg == LAST_TONE) || (tone_reg == 2'd1 && ch[bit_reg]);
                    half_len = slow ? SLOW_HALF : FAST_HALF;
                    periods  = slow ? SLOW_PERIODS : FAST_PERIODS;
                    res_new.sample_valid = 1'b1;
                    res_new.sample       = half_low_reg ? SAMPLE_LOW : SAMPLE_HIGH;
                    samp_next = samp_inc;
                    if (samp_inc >= half_len)
                    begin
                        samp_next = 4'd0;
                        if (!half_low_reg)
                        begin
                            half_low_next = 1'b1;
                        end
                        else
                        begin
                            half_low_next = 1'b0;
                            period_next   = period_inc;
                            if (period_inc >= periods)
                            begin
                                period_next = 4'd0;
                                if (tone_reg == LAST_TONE)
                                begin
                                    tone_next = 2'd0;
                                    bit_next  = bit_reg + 3'd1;
                                    if (bit_reg == 3'd7 && ph == PH_EOT && cnt >= EOT_CHARS)
                                    begin
                                        phase_next         = PH_DONE;
                                        count_next         = '0;
                                        res_new.frame_done = 1'b1;
                                    end
                                end
                                else
                                begin
                                    tone_next = tone_reg + 2'd1;
                                end
                            end
                        end
                    end
                end
            end
        end

        // output register
        out_valid_next = out_valid_reg;
        res_next       = res_reg;
        if (cmd_pop)
        begin
            out_valid_next = 1'b1;
            res_next       = res_new;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_SYNC;
            count_reg      <= '0;
            data_sent_reg  <= '0;
            low_nibble_reg <= 1'b0;
            tape_char_reg  <= CH_SYNC;
            bit_reg        <= '0;
            tone_reg       <= '0;
            period_reg     <= '0;
            samp_reg       <= '0;
            half_low_reg   <= 1'b0;
            sum_reg        <= '0;
            held_valid_reg <= 1'b0;
            ended_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            count_reg      <= count_next;
            data_sent_reg  <= data_sent_next;
            low_nibble_reg <= low_nibble_next;
            tape_char_reg  <= tape_char_next;
            bit_reg        <= bit_next;
            tone_reg       <= tone_next;
            period_reg     <= period_next;
            samp_reg       <= samp_next;
            half_low_reg   <= half_low_next;
            sum_reg        <= sum_next;
            held_valid_reg <= held_valid_next;
            ended_reg      <= ended_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_byte_reg <= held_byte_next;
        res_reg       <= res_next;
    end

    // a held byte never outlives the data phase
    assert property (@(posedge clk) disable iff (!rst_n)
        held_valid_reg |-> (phase_reg <= PH_DATA))
        else $error("byte held past data phase");

    // the low nibble is only pending while its byte is held
    assert property (@(posedge clk) disable iff (!rst_n)
        low_nibble_reg |-> held_valid_reg)
        else $error("low nibble pending without held byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.frame_done) |-> (res_reg.sample_valid && phase_reg == PH_DONE))
        else $error("frame end without final sample");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.sample_valid)
        |-> (res_reg.sample == SAMPLE_HIGH || res_reg.sample == SAMPLE_LOW))
        else $error("sample outside the two levels");

endmodule

### src/tape_fsk_frame_encoder.sv
// fsk cassette frame encoder. every input transaction is either a sample tick
// (kind 0) or an offered data byte (kind 1) and yields exactly one output
// transaction. a tick returns the next audio sample (32767 or -32768) with
// sample_valid set, or need_byte when the data phase waits for a byte; the
// tick that ends the last end-of-text character also sets frame_done, and
// ticks after that return all zeros. an offered byte goes into a one-byte
// holding register and returns an empty result, or overrun if it cannot be
// taken. the block sustains one transaction per clock on both sides while
// out_ready stays high; the result of an input transaction passes from the
// input register, which loads at acceptance, through the command queue to
// the output register. all encoder state advances in the single back end
// stage, so one transaction per cycle is its limit. configuration is over
// the apb port: start_address at 0x0, data_length at 0x4, file_id at 0x8;
// they are to be written only while the encoder is idle, which the block
// itself does not enforce. no clearing pass after reset.
module tape_fsk_frame_encoder
    import tfe_pkg::*;
#(
    parameter int unsigned SYNC_CHARS = 100
)
(
    input  logic               clk,
    input  logic               rst_n,
    // apb configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // input channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               kind,
    input  logic [7:0]         data_byte,
    input  logic               last_byte,
    // output channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] sample,
    output logic               sample_valid,
    output logic               need_byte,
    output logic               overrun,
    output logic               frame_done
);

    logic [15:0] start_address_reg;
    logic [15:0] data_length_reg;
    logic [7:0]  file_id_reg;
    logic        cfg_write;
    cfg_t        cfg;

    logic push;
    cmd_t push_cmd;
    logic queue_full;
    logic cmd_pop;
    logic cmd_valid;
    cmd_t cmd;
    res_t res;

    // register file, word index from paddr[3:2]
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_address_reg <= '0;
            data_length_reg   <= '0;
            file_id_reg       <= '0;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_START_ADDRESS: start_address_reg <= pwdata[15:0];
                REG_DATA_LENGTH:   data_length_reg   <= pwdata[15:0];
                REG_FILE_ID:       file_id_reg       <= pwdata[7:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_START_ADDRESS: prdata = {16'd0, start_address_reg};
            REG_DATA_LENGTH:   prdata = {16'd0, data_length_reg};
            REG_FILE_ID:       prdata = {24'd0, file_id_reg};
            default:           prdata = '0;
        endcase
    end

    assign cfg.start_address = start_address_reg;
    assign cfg.data_length   = data_length_reg;
    assign cfg.file_id       = file_id_reg;

    // front: takes and classifies each transaction
    tfe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .push       (push),
        .push_cmd   (push_cmd),
        .queue_full (queue_full)
    );

    // short command queue decouples front and back stalls
    tfe_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (queue_full),
        .pop       (cmd_pop),
        .pop_valid (cmd_valid),
        .pop_cmd   (cmd)
    );

    // back: frame sequencer, tone generator, holding register
    tfe_back #(
        .SYNC_CHARS (SYNC_CHARS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res       (res)
    );

    assign sample       = res.sample;
    assign sample_valid = res.sample_valid;
    assign need_byte    = res.need_byte;
    assign overrun      = res.overrun;
    assign frame_done   = res.frame_done;

endmodule

### verif/tb_tape_fsk_frame_encoder.sv
module tb_tape_fsk_frame_encoder;
    timeunit 1ns;
    timeprecision 1ps;

    import tfe_pkg::*;

    // the block only starts one frame per reset, so the sync run is cut to two
    // characters; at 2592 ticks a character the run stays near the frame start
    localparam int unsigned SYNC_LEN    = 2;
    localparam int unsigned ITEM_COUNT  = 700;
    // no idling on either side for this many transactions at the end
    localparam int unsigned CALM_ITEMS  = 100;
    localparam int unsigned CYCLE_LIMIT = 300_000;
    // output register, two-entry queue, input register, plus some slack
    localparam int unsigned SETTLE      = 8;
    localparam int unsigned GAP_MAX     = 18;
    localparam int unsigned PRINT_MAX   = 40;

    // shadow copy of the encoder: state, registers and the results still owed
    class fsk_frame_shadow;
        cfg_t        cfg;
        phase_t      phase;
        logic [6:0]  chars_in_phase;
        logic [15:0] bytes_taken;
        logic [15:0] byte_sum;
        logic        low_half_due;
        logic [7:0]  cur_char;
        logic [2:0]  bit_pos;
        logic [1:0]  tone;
        logic [3:0]  period;
        logic [3:0]  step;
        logic        in_low;
        logic [7:0]  hold_byte;
        logic        hold_full;
        logic        feed_ended;
        int unsigned sync_total;
        res_t        pending_samples[$];
        int unsigned mismatches;
        int unsigned checked;
        int unsigned refused;
        int unsigned starved;

        function new(int unsigned sync_chars);
            cfg            = '0;
            phase          = PH_SYNC;
            chars_in_phase = '0;
            bytes_taken    = '0;
            byte_sum       = '0;
            low_half_due   = 1'b0;
            cur_char       = CH_SYNC;
            bit_pos        = '0;
            tone           = '0;
            period         = '0;
            step           = '0;
            in_low         = 1'b0;
            hold_byte      = '0;
            hold_full      = 1'b0;
            feed_ended     = 1'b0;
            sync_total     = sync_chars;
            mismatches     = 0;
            checked        = 0;
            refused        = 0;
            starved        = 0;
        endfunction

        task report_mismatch(string what);
            mismatches++;
            if (mismatches <= PRINT_MAX)
                $display("mismatch: %s", what);
        endtask

        function logic [7:0] ascii_hex(logic [3:0] n);
            logic [7:0] code;
            code = CH_DIGIT + {4'd0, n};
            if (n > 4'd9)
                code = code + (CH_ALPHA - CH_DIGIT - 8'd10);
            return code;
        endfunction

        // word digits go low byte first, high nibble before low nibble
        function logic [7:0] word_digit(logic [15:0] w, logic [1:0] k);
            logic [1:0] pos;
            pos = {k[1], ~k[0]};
            return ascii_hex(w[{pos, 2'b00} +: 4]);
        endfunction

        function logic at_char_start();
            return bit_pos == 3'd0 && tone == 2'd0 && period == 4'd0 &&
                   step == 4'd0 && !in_low;
        endfunction

        // the next tick would stall on an empty holding register
        function logic wants_byte();
            return phase == PH_DATA && at_char_start() && !low_half_due &&
                   !hold_full && !feed_ended && bytes_taken < cfg.data_length;
        endfunction

        // picks the character that starts now, stepping over finished phases
        function logic next_char();
            int unsigned limit;
            logic [7:0]  text;
            logic [15:0] sum;
            sum = byte_sum + {8'd0, cfg.start_address[7:0]} +
                  {8'd0, cfg.start_address[15:8]};
            while (1'b1)
            begin
                if (phase == PH_DONE)
                    return 1'b0;
                if (phase == PH_DATA)
                begin
                    if (low_half_due)
                    begin
                        cur_char     = ascii_hex(hold_byte[3:0]);
                        hold_full    = 1'b0;
                        low_half_due = 1'b0;
                        return 1'b1;
                    end
                    if (hold_full)
                    begin
                        cur_char     = ascii_hex(hold_byte[7:4]);
                        low_half_due = 1'b1;
                        return 1'b1;
                    end
                    if (!feed_ended && bytes_taken < cfg.data_length)
                        return 1'b0;
                end
                else
                begin
                    case (phase)
                        PH_SYNC:
                        begin
                            limit = sync_total;
                            text  = CH_SYNC;
                        end
                        PH_MARK:
                        begin
                            limit = MARK_CHARS;
                            text  = CH_MARK;
                        end
                        PH_ID:
                        begin
                            limit = ID_CHARS;
                            text  = ascii_hex(chars_in_phase == 7'd0 ? cfg.file_id[7:4]
                                                                     : cfg.file_id[3:0]);
                        end
                        PH_ADDR:
                        begin
                            limit = ADDR_CHARS;
                            text  = word_digit(cfg.start_address, chars_in_phase[1:0]);
                        end
                        PH_DEND:
                        begin
                            limit = DEND_CHARS;
                            text  = CH_DEND;
                        end
                        PH_CSUM:
                        begin
                            limit = CSUM_CHARS;
                            text  = word_digit(sum, chars_in_phase[1:0]);
                        end
                        default:
                        begin
                            limit = EOT_CHARS;
                            text  = CH_EOT;
                        end
                    endcase
                    if (chars_in_phase < limit)
                    begin
                        cur_char       = text;
                        chars_in_phase = chars_in_phase + 7'd1;
                        return 1'b1;
                    end
                end
                phase          = phase_t'(phase + 1);
                chars_in_phase = '0;
            end
            return 1'b0;
        endfunction

        // one accepted input transaction, one result owed
        function void take_transaction(cmd_t c);
            res_t       r;
            logic       ok;
            logic       slow;
            logic [3:0] half_len;
            logic [3:0] periods;
            r = '0;
            if (c.op == OP_BYTE)
            begin
                if (phase <= PH_DATA && !hold_full && !feed_ended &&
                    bytes_taken < cfg.data_length)
                begin
                    hold_byte   = c.data_byte;
                    hold_full   = 1'b1;
                    bytes_taken = bytes_taken + 16'd1;
                    byte_sum    = byte_sum + {8'd0, c.data_byte};
                    if (c.last_byte)
                        feed_ended = 1'b1;
                end
                else
                begin
                    r.overrun = 1'b1;
                    refused++;
                end
            end
            else if (phase != PH_DONE)
            begin
                ok = 1'b1;
                if (at_char_start())
                    ok = next_char();
                if (!ok)
                begin
                    r.need_byte = (phase == PH_DATA);
                    starved++;
                end
                else
                begin
                    slow     = (tone == LAST_TONE) || (tone == 2'd1 && cur_char[bit_pos]);
                    half_len = slow ? SLOW_HALF : FAST_HALF;
                    periods  = slow ? SLOW_PERIODS : FAST_PERIODS;
                    r.sample_valid = 1'b1;
                    r.sample       = in_low ? SAMPLE_LOW : SAMPLE_HIGH;
                    step = step + 4'd1;
                    if (step >= half_len)
                    begin
                        step = '0;
                        if (!in_low)
                            in_low = 1'b1;
                        else
                        begin
                            in_low = 1'b0;
                            period = period + 4'd1;
                            if (period >= periods)
                            begin
                                period = '0;
                                tone   = tone + 2'd1;
                                if (tone > LAST_TONE)
                                begin
                                    tone    = '0;
                                    bit_pos = bit_pos + 3'd1;
                                    if (bit_pos == 3'd0 && phase == PH_EOT &&
                                        chars_in_phase >= EOT_CHARS)
                                    begin
                                        phase          = PH_DONE;
                                        chars_in_phase = '0;
                                        r.frame_done   = 1'b1;
                                    end
                                end
                            end
                        end
                    end
                end
            end
            pending_samples.push_back(r);
        endfunction

        task check_sample(res_t got);
            res_t want;
            if (pending_samples.size() == 0)
            begin
                report_mismatch($sformatf("result %0d arrived with nothing owed", checked));
                return;
            end
            want = pending_samples.pop_front();
            if (got.sample !== want.sample)
                report_mismatch($sformatf("result %0d sample %0d, want %0d",
                                          checked, got.sample, want.sample));
            if (got.sample_valid !== want.sample_valid)
                report_mismatch($sformatf("result %0d sample_valid %b, want %b",
                                          checked, got.sample_valid, want.sample_valid));
            if (got.need_byte !== want.need_byte)
                report_mismatch($sformatf("result %0d need_byte %b, want %b",
                                          checked, got.need_byte, want.need_byte));
            if (got.overrun !== want.overrun)
                report_mismatch($sformatf("result %0d overrun %b, want %b",
                                          checked, got.overrun, want.overrun));
            if (got.frame_done !== want.frame_done)
                report_mismatch($sformatf("result %0d frame_done %b, want %b",
                                          checked, got.frame_done, want.frame_done));
            checked++;
        endtask
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid;
    logic               in_ready;
    logic               kind;
    logic [7:0]         data_byte;
    logic               last_byte;
    logic               out_valid;
    logic               out_ready;
    logic signed [15:0] sample;
    logic               sample_valid;
    logic               need_byte;
    logic               overrun;
    logic               frame_done;

    fsk_frame_shadow shadow;
    int unsigned     gap_odds;
    int unsigned     stall_odds;
    int unsigned     items_sent;
    int unsigned     cfg_writes;
    int unsigned     cycle_count;
    logic            calm;

    tape_fsk_frame_encoder #(
        .SYNC_CHARS (SYNC_LEN)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sample       (sample),
        .sample_valid (sample_valid),
        .need_byte    (need_byte),
        .overrun      (overrun),
        .frame_done   (frame_done)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // both channels sampled at the rising edge; the result is checked before
    // the input transaction of the same edge is noted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                shadow.check_sample(res_t'{sample, sample_valid, need_byte, overrun,
                                           frame_done});
            if (in_valid && in_ready)
                shadow.take_transaction(cmd_t'{op_t'(kind), data_byte, last_byte});
        end
    end

    // output side back-pressure, in bursts, switched off near the end
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_odds != 0 && $urandom_range(0, stall_odds) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, GAP_MAX)) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("run stuck after %0d cycles, %0d results outstanding",
                 cycle_count, shadow.pending_samples.size());
        $display("tape_fsk_frame_encoder test failed");
        $finish;
    end

    // one input transaction; entered and left at a falling edge, valid stays
    // high on return so back-to-back transactions need no extra step
    task automatic send_item(input op_t op, input logic [7:0] b, input logic last);
        if (gap_odds != 0 && $urandom_range(0, gap_odds) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, GAP_MAX)) @(negedge clk);
        end
        in_valid  <= 1'b1;
        kind      <= op;
        data_byte <= b;
        last_byte <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    // stop sending and let every owed result come back
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (shadow.pending_samples.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_START_ADDRESS: shadow.cfg.start_address = val[15:0];
            REG_DATA_LENGTH:   shadow.cfg.data_length   = val[15:0];
            default:           shadow.cfg.file_id       = val[7:0];
        endcase
        cfg_writes++;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic reg_check(input logic [1:0] idx);
        logic [31:0] want;
        logic [31:0] mask;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_START_ADDRESS:
            begin
                want = {16'd0, shadow.cfg.start_address};
                mask = 32'h0000_FFFF;
            end
            REG_DATA_LENGTH:
            begin
                want = {16'd0, shadow.cfg.data_length};
                mask = 32'h0000_FFFF;
            end
            default:
            begin
                want = {24'd0, shadow.cfg.file_id};
                mask = 32'h0000_00FF;
            end
        endcase
        if ((prdata & mask) !== want)
            shadow.report_mismatch($sformatf("register %0d reads %h, want %h",
                                             idx, prdata & mask, want));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // write all three registers and read them back; only called when idle
    task automatic load_settings(input logic [15:0] sa, input logic [15:0] dl,
                                 input logic [7:0] fid);
        reg_write(REG_START_ADDRESS, {16'd0, sa});
        reg_write(REG_DATA_LENGTH, {16'd0, dl});
        reg_write(REG_FILE_ID, {24'd0, fid});
        reg_check(REG_START_ADDRESS);
        reg_check(REG_DATA_LENGTH);
        reg_check(REG_FILE_ID);
    endtask

    initial
    begin
        logic [15:0] sa;
        logic [15:0] dl;
        logic [7:0]  fid;
        int unsigned next_cfg;

        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        in_valid   = 1'b0;
        kind       = 1'b0;
        data_byte  = '0;
        last_byte  = 1'b0;
        gap_odds   = 3;
        stall_odds = 3;
        items_sent = 0;
        cfg_writes = 0;
        calm       = 1'b0;
        shadow     = new(SYNC_LEN);

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // registers come out of reset at zero
        reg_check(REG_START_ADDRESS);
        reg_check(REG_DATA_LENGTH);
        reg_check(REG_FILE_ID);

        // zero length: any offered byte is refused, last flag or not
        load_settings(16'h0000, 16'h0000, 8'h00);
        send_item(OP_BYTE, 8'hA5, 1'b1);
        send_item(OP_TICK, 8'hFF, 1'b1);
        send_item(OP_TICK, 8'h00, 1'b0);
        drain();

        // largest settings; one byte fits the holding register, the next is
        // refused while it is full
        load_settings(16'hFFFF, 16'hFFFF, 8'hFF);
        send_item(OP_BYTE, 8'h00, 1'b0);
        send_item(OP_BYTE, 8'hFF, 1'b1);
        send_item(OP_TICK, 8'h5A, 1'b0);
        send_item(OP_TICK, 8'hA5, 1'b1);
        send_item(OP_BYTE, 8'h5A, 1'b0);
        send_item(OP_TICK, 8'h00, 1'b0);
        drain();

        load_settings(16'h8001, 16'd3, 8'h3C);
        repeat (6) send_item(OP_TICK, 8'($urandom), 1'($urandom));
        drain();

        // random part: mostly ticks, bytes fed when the encoder starves,
        // stray offers as noise, settings changed now and then
        next_cfg = items_sent + $urandom_range(100, 250);
        while (items_sent < ITEM_COUNT)
        begin
            // the last stretch runs with no idling on either side
            if (!calm && items_sent + CALM_ITEMS >= ITEM_COUNT)
            begin
                calm       = 1'b1;
                gap_odds   = 0;
                stall_odds = 0;
            end
            if (!calm && items_sent >= next_cfg)
            begin
                drain();
                case ($urandom_range(0, 3))
                    0:       sa = 16'h0000;
                    1:       sa = 16'hFFFF;
                    default: sa = 16'($urandom);
                endcase
                case ($urandom_range(0, 3))
                    0:       fid = 8'h00;
                    1:       fid = 8'hFF;
                    default: fid = 8'($urandom);
                endcase
                // keep the byte budget near what has been taken so the
                // frame stays short; zero ends the data phase once no byte is held
                if ($urandom_range(0, 7) == 0)
                    dl = 16'd0;
                else
                    dl = shadow.bytes_taken + 16'($urandom_range(0, 2));
                load_settings(sa, dl, fid);
                case ($urandom_range(0, 2))
                    0:       gap_odds = 0;
                    1:       gap_odds = 3;
                    default: gap_odds = 15;
                endcase
                case ($urandom_range(0, 2))
                    0:       stall_odds = 0;
                    1:       stall_odds = 3;
                    default: stall_odds = 15;
                endcase
                next_cfg = items_sent + $urandom_range(100, 250);
            end
            if (shadow.wants_byte() && $urandom_range(0, 3) != 0)
                send_item(OP_BYTE, 8'($urandom), $urandom_range(0, 5) == 0);
            else if ($urandom_range(0, 79) == 0)
                send_item(OP_BYTE, 8'($urandom), 1'($urandom));
            else
                send_item(OP_TICK, 8'($urandom), 1'($urandom));
        end

        drain();

        $display("frame start with %0d sync chars, reached phase %s, %0d data bytes taken",
                 SYNC_LEN, shadow.phase.name(), shadow.bytes_taken);
        $display("%0d transactions, %0d results, %0d refused, %0d starved, %0d reg writes",
                 items_sent, shadow.checked, shadow.refused, shadow.starved, cfg_writes);
        if (shadow.mismatches == 0)
        begin
            $display("tape_fsk_frame_encoder test passed");
        end
        else
        begin
            $display("tape_fsk_frame_encoder test failed");
        end
        $finish;
    end

endmodule
